// File: rtl/core/olpd_pkg.sv
// ----------------------------------------------------------------------------
// olpd_pkg: shared types and constants for the ordered list block
// Opcodes, status codes, controller states and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package olpd_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_END   = 3'd3,
        OP_DEL_POS   = 3'd4,
        OP_LIST      = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_op;    // capture the accepted beat
        logic exec;       // run a single-result operation and load its result
        logic list_emit;  // load the next entry of a list-all walk
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // result register can take a new beat this cycle
        logic list_go;    // captured op is list-all on a non-empty list
        logic list_done;  // current walk position is the final entry
    } sts_t;

endpackage

// File: rtl/core/olpd_req_if.sv
// ----------------------------------------------------------------------------
// olpd_req_if: request channel
// Carries one operation per beat: mode, value and position.
// ----------------------------------------------------------------------------
interface olpd_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [olpd_pkg::MODE_W-1:0]          mode;
    logic signed [olpd_pkg::VALUE_W-1:0]  value;
    logic [olpd_pkg::POS_W-1:0]           position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

// File: rtl/core/olpd_rsp_if.sv
// ----------------------------------------------------------------------------
// olpd_rsp_if: result channel
// Carries one result per beat: status, entry value, entry count and last.
// ----------------------------------------------------------------------------
interface olpd_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [olpd_pkg::STATUS_W-1:0]        status;
    logic signed [olpd_pkg::VALUE_W-1:0]  entry_value;
    logic [olpd_pkg::COUNT_W-1:0]         entry_count;
    logic                                 last;

    modport source (output valid, output status, output entry_value, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input status, input entry_value, input entry_count,
                    input last, output ready);
endinterface

// File: rtl/core/olpd_ctrl.sv
// ----------------------------------------------------------------------------
// olpd_ctrl: operation sequencer
// Accepts a request beat, waits for the result register, then either runs
// the operation and loads its single result, or walks the list one entry per result beat.
// ----------------------------------------------------------------------------
module olpd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  olpd_pkg::sts_t   sts,
    output olpd_pkg::cmd_t   cmd
);
    import olpd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.list_go ? S_LIST : S_IDLE;
                end
            end
            S_LIST:
            begin
                if (sts.out_free && sts.list_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.load_op = req_valid;
            end
            S_EXEC:
            begin
                // a non-empty list-all goes straight to the walk
                cmd.exec = sts.out_free && !sts.list_go;
            end
            S_LIST:
            begin
                cmd.list_emit = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.list_emit) |-> sts.out_free)
        else $error("result loaded while result register busy");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_op, cmd.exec, cmd.list_emit}))
        else $error("more than one datapath command in a cycle");

    a_walk_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST && cmd.list_emit && sts.list_done) |=> state_reg == S_IDLE)
        else $error("list walk did not end after final entry");

endmodule

// File: rtl/core/olpd_dpath.sv
// ----------------------------------------------------------------------------
// olpd_dpath: list cells, entry count and result register
// Cell 0 is the front. Inserts and deletes shift the whole row in parallel;
// list-all reads one cell per result beat.
// ----------------------------------------------------------------------------
module olpd_dpath
#(
    parameter int CAPACITY = olpd_pkg::CAPACITY_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [olpd_pkg::MODE_W-1:0]           mode,
    input  logic signed [olpd_pkg::VALUE_W-1:0]   value,
    input  logic [olpd_pkg::POS_W-1:0]            position,
    input  olpd_pkg::cmd_t                        cmd,
    output olpd_pkg::sts_t                        sts,
    olpd_rsp_if.source                            rsp
);
    import olpd_pkg::*;

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [VALUE_W-1:0]  cells_reg [CAPACITY];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [IW-1:0]       list_idx_reg;

    logic [MODE_W-1:0]   mode_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [POS_W-1:0]    pos_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_last_reg;

    logic [STATUS_W-1:0] ex_status;
    logic                ex_read;
    logic                ins_front;
    logic                ins_end;
    logic                del_en;
    logic [IW-1:0]       del_idx;
    logic [IW-1:0]       rd_idx;
    logic [VALUE_W-1:0]  rd_data;
    logic [CMPW-1:0]     pos_ext;
    logic [CMPW-1:0]     count_ext;
    logic [CMPW-1:0]     count_next_ext;

    assign pos_ext        = CMPW'(pos_reg);
    assign count_ext      = CMPW'(count_reg);
    assign count_next_ext = CMPW'(count_next);

    // decode the captured operation against the current count
    always_comb
    begin
        ex_status = ST_OK;
        ex_read   = 1'b0;
        ins_front = 1'b0;
        ins_end   = 1'b0;
        del_en    = 1'b0;
        del_idx   = '0;
        unique case (mode_reg)
            OP_INS_FRONT, OP_INS_END:
            begin
                if (count_reg == CAP_C)
                begin
                    ex_status = ST_FULL;
                end
                else
                begin
                    ins_front = (mode_reg == OP_INS_FRONT);
                    ins_end   = (mode_reg == OP_INS_END);
                end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS:
            begin
                if (count_reg == '0)
                begin
                    ex_status = ST_EMPTY;
                end
                else if (mode_reg == OP_DEL_POS &&
                         (pos_ext == '0 || pos_ext > count_ext))
                begin
                    ex_status = ST_INVALID;
                end
                else
                begin
                    del_en  = 1'b1;
                    ex_read = 1'b1;
                    if (mode_reg == OP_DEL_FRONT)
                    begin
                        del_idx = '0;
                    end
                    else if (mode_reg == OP_DEL_END)
                    begin
                        del_idx = IW'(count_reg - CW'(1));
                    end
                    else
                    begin
                        del_idx = IW'(pos_ext - CMPW'(1));
                    end
                end
            end
            OP_LIST:
            begin
                ex_status = ST_EMPTY;   // only reached on an empty list
            end
            default:
            begin
                ex_status = ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec && (ins_front || ins_end))
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.exec && del_en)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign rd_idx  = cmd.list_emit ? list_idx_reg : del_idx;
    assign rd_data = cells_reg[rd_idx];

    assign sts.out_free  = !out_valid_reg || rsp.ready;
    assign sts.list_go   = (mode_reg == OP_LIST) && (count_reg != '0);
    assign sts.list_done = (CW'(list_idx_reg) == count_reg - CW'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            mode_reg  <= mode;
            value_reg <= value;
            pos_reg   <= position;
        end
    end

    // shift the row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (cmd.exec && ins_front)
            begin
                cells_reg[i] <= (i == 0) ? value_reg : cells_reg[(i == 0) ? 0 : i - 1];
            end
            else if (cmd.exec && ins_end && count_reg == CW'(i))
            begin
                cells_reg[i] <= value_reg;
            end
            else if (cmd.exec && del_en && IW'(i) >= del_idx && i < CAPACITY - 1)
            begin
                cells_reg[i] <= cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            list_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load_op)
            begin
                list_idx_reg <= '0;
            end
            else if (cmd.list_emit)
            begin
                list_idx_reg <= list_idx_reg + IW'(1);
            end
            if (cmd.exec || cmd.list_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_status_reg <= ex_status;
            out_value_reg  <= ex_read ? rd_data : '0;
            out_count_reg  <= count_next_ext[COUNT_W-1:0];
            out_last_reg   <= 1'b1;
        end
        else if (cmd.list_emit)
        begin
            out_status_reg <= ST_OK;
            out_value_reg  <= rd_data;
            out_count_reg  <= count_ext[COUNT_W-1:0];
            out_last_reg   <= sts.list_done;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_value = out_value_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.last        = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && ex_status != ST_OK) |=> $stable(count_reg))
        else $error("count changed on a rejected operation");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.list_emit |-> CW'(list_idx_reg) < count_reg)
        else $error("list walk beyond stored entries");

endmodule

// File: rtl/core/ordered_list_with_positional_delete_top.sv
// ----------------------------------------------------------------------------
// ordered_list_with_positional_delete_top: bounded ordered list of words
// Insert/delete at front, end or position, and list-all, on a row of cells.
// ----------------------------------------------------------------------------
// Operation: a request beat is taken in IDLE; an insert or delete result is loaded in EXEC
//   when the result register is free, a list walk's entries one by one in LIST after EXEC.
// Flow: a new request is taken only back in IDLE, after the last result is loaded; list-all
//   gives one result beat per cycle per entry while the result register is free.
// Reset: rst_n clears the count (list empty) and the handshake state at once.
module ordered_list_with_positional_delete_top
#(
    parameter int CAPACITY = olpd_pkg::CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    olpd_req_if.sink    req,
    olpd_rsp_if.source  rsp
);
    import olpd_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic ctrl_ready;

    assign req.ready = ctrl_ready;

    olpd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctrl_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    olpd_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (req.mode),
        .value    (req.value),
        .position (req.position),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp)
    );

endmodule

// File: tb/sv/ordered_list_with_positional_delete_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_with_positional_delete_top_tb: self-checking bench for the list
// Drives directed and random list operations on the request channel. A
// scoreboard keeps its own copy of the list, predicts every result beat and
// checks the result channel beat by beat, with random idling on both sides.
// ----------------------------------------------------------------------------
module ordered_list_with_positional_delete_top_tb;
    import olpd_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 2 * CAP + 8;
    localparam int MAX_REPORTS  = 100;

    // modes outside the defined set, answered as invalid
    localparam logic [MODE_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [MODE_W-1:0] OP_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  entry_value;
        logic [COUNT_W-1:0]  entry_count;
        logic                last;
    } rsp_beat_t;

    class list_scoreboard;
        logic [VALUE_W-1:0] cells [CAP];
        int unsigned        count;
        rsp_beat_t          pending [$];
        int                 errors;
        int                 beats_checked;
        int                 list_beats;
        int                 status_seen [4];

        function new();
            count         = 0;
            errors        = 0;
            beats_checked = 0;
            list_beats    = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void push_beat(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] v, logic l);
            rsp_beat_t b;
            b.status      = st;
            b.entry_value = v;
            b.entry_count = COUNT_W'(count);
            b.last        = l;
            pending.push_back(b);
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                                   logic [POS_W-1:0] pos);
            int unsigned        idx;
            logic [VALUE_W-1:0] removed;
            case (mode)
                OP_INS_FRONT, OP_INS_END:
                begin
                    if (count >= CAP)
                        push_beat(ST_FULL, '0, 1'b1);
                    else
                    begin
                        if (mode == OP_INS_FRONT)
                        begin
                            for (int i = count; i > 0; i--)
                                cells[i] = cells[i-1];
                            cells[0] = value;
                        end
                        else
                            cells[count] = value;
                        count++;
                        push_beat(ST_OK, '0, 1'b1);
                    end
                end
                OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS:
                begin
                    if (count == 0)
                        push_beat(ST_EMPTY, '0, 1'b1);
                    else if (mode == OP_DEL_POS && (pos < 1 || pos > count))
                        push_beat(ST_INVALID, '0, 1'b1);
                    else
                    begin
                        if (mode == OP_DEL_FRONT)
                            idx = 0;
                        else if (mode == OP_DEL_END)
                            idx = count - 1;
                        else
                            idx = pos - 1;
                        removed = cells[idx];
                        // close the gap left by the removed entry
                        for (int unsigned i = idx; i + 1 < count; i++)
                            cells[i] = cells[i+1];
                        count--;
                        push_beat(ST_OK, removed, 1'b1);
                    end
                end
                OP_LIST:
                begin
                    if (count == 0)
                        push_beat(ST_EMPTY, '0, 1'b1);
                    else
                        for (int unsigned i = 0; i < count; i++)
                        begin
                            push_beat(ST_OK, cells[i], (i + 1 == count));
                            list_beats++;
                        end
                end
                default:
                    push_beat(ST_INVALID, '0, 1'b1);
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_result(rsp_beat_t got);
            rsp_beat_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("beat with nothing pending: st=%0d val=%0d cnt=%0d last=%0b",
                                          got.status, $signed(got.entry_value),
                                          got.entry_count, got.last));
                return;
            end
            want = pending.pop_front();
            beats_checked++;
            status_seen[want.status]++;
            if (got.status !== want.status || got.entry_value !== want.entry_value ||
                got.entry_count !== want.entry_count || got.last !== want.last)
                report_mismatch($sformatf("got st=%0d val=%0d cnt=%0d last=%0b, want st=%0d val=%0d cnt=%0d last=%0b",
                                          got.status, $signed(got.entry_value),
                                          got.entry_count, got.last,
                                          want.status, $signed(want.entry_value),
                                          want.entry_count, want.last));
        endtask
    endclass

    logic clk;
    logic rst_n;

    olpd_req_if req_ch ();
    olpd_rsp_if rsp_ch ();

    ordered_list_with_positional_delete_top #(
        .CAPACITY (CAP)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_scoreboard sb;
    rsp_beat_t      seen_beat;
    bit             tx_idle_en;
    bit             rx_idle_en;
    bit             hold_req;
    int             items_sent;
    int             stall_cycles;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly a live position, now and then any position from 0 to CAP
    function automatic logic [POS_W-1:0] pick_position();
        if (sb.count > 0 && $urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(1, sb.count));
        return POS_W'($urandom_range(0, CAP));
    endfunction

    task automatic send_op(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos);
        int gap;
        if (tx_idle_en && $urandom_range(0, 99) < 25)
        begin
            gap = pick_gap();
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= op;
        req_ch.value    <= val;
        req_ch.position <= pos;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic random_phase(input int n);
        int target;
        int k;
        logic [MODE_W-1:0] op;
        target = items_sent + n;
        while (items_sent < target)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4:
                begin
                    // fill run, often running into a full list
                    k = $urandom_range(1, CAP + 2 - sb.count);
                    repeat (k)
                        send_op($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_END,
                                rand_value(), POS_W'($urandom_range(0, CAP)));
                end
                5, 6, 7, 8, 9:
                begin
                    // drain run, often past empty
                    k = $urandom_range(1, sb.count + 2);
                    repeat (k)
                    begin
                        case ($urandom_range(0, 2))
                            0:       op = OP_DEL_FRONT;
                            1:       op = OP_DEL_END;
                            default: op = OP_DEL_POS;
                        endcase
                        send_op(op, rand_value(), pick_position());
                    end
                end
                10, 11:
                    send_op(OP_LIST, rand_value(), POS_W'($urandom_range(0, CAP)));
                default:
                begin
                    repeat (8)
                    begin
                        case ($urandom_range(0, 99)) inside
                            [0:19]:  op = OP_INS_FRONT;
                            [20:39]: op = OP_INS_END;
                            [40:49]: op = OP_DEL_FRONT;
                            [50:59]: op = OP_DEL_END;
                            [60:79]: op = OP_DEL_POS;
                            [80:94]: op = OP_LIST;
                            [95:97]: op = OP_RSVD_6;
                            default: op = OP_RSVD_7;
                        endcase
                        send_op(op, rand_value(), pick_position());
                    end
                end
            endcase
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        bit hold_done;
        stall_left   = 0;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 99) < 20)
            begin
                stall_left = pick_gap() - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen_beat.status      = rsp_ch.status;
                seen_beat.entry_value = rsp_ch.entry_value;
                seen_beat.entry_count = rsp_ch.entry_count;
                seen_beat.last        = rsp_ch.last;
                sb.check_result(seen_beat);
            end
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.mode, req_ch.value, req_ch.position);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles = 0;
        else
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= IDLE_LIMIT)
                begin
                    $display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
                    $display("ordered_list_with_positional_delete_top: mismatch");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] v;
        sb                 = new();
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = OP_INS_FRONT;
        req_ch.value       = '0;
        req_ch.position    = '0;
        tx_idle_en         = 1'b1;
        rx_idle_en         = 1'b1;
        hold_req           = 1'b0;
        items_sent         = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list and undefined modes
        send_op(OP_LIST, '0, '0);
        send_op(OP_DEL_FRONT, '0, '0);
        send_op(OP_DEL_END, '0, '0);
        send_op(OP_DEL_POS, '0, 5'd1);
        send_op(OP_RSVD_6, 32'hFFFF_FFFF, 5'd31);
        send_op(OP_RSVD_7, 32'h8000_0000, 5'd16);

        // fill to capacity from both ends, then push one more
        for (int i = 0; i < CAP; i++)
        begin
            case (i)
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                2:       v = 32'h0000_0000;
                3:       v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            send_op((i % 2) ? OP_INS_END : OP_INS_FRONT, v, '0);
        end
        send_op(OP_INS_FRONT, 32'h1234_5678, '0);
        send_op(OP_LIST, '0, '0);

        // position zero, the final position (tail moves back), then out of range
        send_op(OP_DEL_POS, '0, 5'd0);
        send_op(OP_DEL_POS, '0, 5'd16);
        send_op(OP_DEL_POS, '0, 5'd16);
        send_op(OP_LIST, '0, '0);

        random_phase(120);

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_phase(60);

        // hold the result side off while requests keep coming
        hold_req   = 1'b1;
        rx_idle_en = 1'b1;
        random_phase(40);

        tx_idle_en = 1'b1;
        random_phase(80);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d operations and %0d result beats, %0d of them from list walks.",
                 items_sent, sb.beats_checked, sb.list_beats);
        $display("Statuses: ok %0d, empty %0d, full %0d, invalid %0d; %0d bad beats.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_INVALID], sb.errors);
        if (sb.errors == 0)
            $display("ordered_list_with_positional_delete_top: match");
        else
            $display("ordered_list_with_positional_delete_top: mismatch");
        $finish;
    end

endmodule

// File: ordered_list_with_positional_delete_top.f
rtl/core/olpd_pkg.sv
rtl/core/olpd_req_if.sv
rtl/core/olpd_rsp_if.sv
rtl/core/olpd_ctrl.sv
rtl/core/olpd_dpath.sv
rtl/core/ordered_list_with_positional_delete_top.sv
tb/sv/ordered_list_with_positional_delete_top_tb.sv
